### hw/rtl/affine_gap_path_scorer_unit_assert.svh
// Assertion macros shared by the scorer RTL.
// Each macro expects clk and arst_n in scope.
`ifndef AFFINE_GAP_PATH_SCORER_UNIT_ASSERT_SVH
`define AFFINE_GAP_PATH_SCORER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define AGPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define AGPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/agps_pkg.sv
package agps_pkg;

	// Default build parameters
	localparam int ALPHABET_SIZE_DEF = 26;
	localparam int SCORE_WIDTH_DEF   = 16;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXTEND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_MODE  = 2'd2;

	// Register reset values (Q.4)
	localparam logic signed [15:0] GAP_OPEN_RST   = -16'sd160;
	localparam logic signed [15:0] GAP_EXTEND_RST = -16'sd16;

	// Request types
	localparam logic REQ_STEP  = 1'b0;
	localparam logic REQ_TABLE = 1'b1;

	// Path operations; code 3 is a non-match step that scores nothing
	localparam logic [1:0] OP_MATCH  = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;

	// ASCII bounds
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHR_LOWER_A = 8'h61;
	localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// Letter index width (A..Z)
	localparam int LETTER_W = 5;

	typedef struct packed {
		logic                req_type;
		logic [1:0]          path_op;
		logic [7:0]          residue_a;
		logic [7:0]          residue_b;
		logic                last_step;
		logic [4:0]          table_row;
		logic [4:0]          table_col;
		logic signed [15:0]  table_value;
	} in_t;

	typedef struct packed {
		logic signed [31:0]  path_score;
		logic                saturated;
	} out_t;

endpackage

### hw/rtl/affine_gap_path_scorer_unit.sv
// Channel | Signals                    | Item
// in      | in_valid, in_stall, in_data | path step or table write (agps_pkg::in_t)
// out     | out_valid, out_stall, out_data | final path score (agps_pkg::out_t)
// cfg     | cfg_we, cfg_index, cfg_data | gap_open, gap_extend, mask_mode
//
// One item per cycle while in_stall is low; a score passes stage 1, then out_q.
// Stage 1 holds the registered table read, stage 2 the single saturating add.
// arst_n clears control and path state, resets the config registers, not the table.
// in_stall rises only while a finished score waits and another last step is in stage 1.
`include "affine_gap_path_scorer_unit_assert.svh"

module affine_gap_path_scorer_unit #(
	parameter int ALPHABET_SIZE = agps_pkg::ALPHABET_SIZE_DEF,
	parameter int SCORE_WIDTH   = agps_pkg::SCORE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  agps_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output agps_pkg::out_t                      out_data,
	input  logic                                cfg_we,
	input  logic [agps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [agps_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import agps_pkg::*;

	localparam int DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] ALPHA_A = ADDR_W'(ALPHABET_SIZE);
	localparam logic [5:0] ALPHA_LIM = 6'(ALPHABET_SIZE);
	localparam logic signed [32:0] SCORE_HI = (33'sd1 <<< (SCORE_WIDTH - 1)) - 33'sd1;
	localparam logic signed [32:0] SCORE_LO = -SCORE_HI - 33'sd1;

	// Configuration registers
	logic signed [15:0] gap_open_q;
	logic signed [15:0] gap_extend_q;
	logic               mask_mode_q;

	// Stage 1
	logic                      valid_s1;
	logic [1:0]                op_s1;
	logic                      last_s1;
	logic                      hit_s1;
	logic signed [SCORE_WIDTH-1:0] rdata_s1;

	// Path state and output register
	logic signed [31:0] score_q;
	logic [1:0]         prev_op_q;
	logic               sat_seen_q;
	logic               out_valid_q;
	out_t               out_q;

	logic signed [SCORE_WIDTH-1:0] mem [DEPTH];

	logic                in_accept;
	logic                s1_hold;
	logic                fire_s2;
	logic [7:0]          chr_a, chr_b;
	logic [LETTER_W-1:0] idx_a, idx_b;
	logic                ok_a, ok_b;
	logic [ADDR_W-1:0]   rd_addr, wr_addr;
	logic                wr_en;
	logic signed [32:0]  wr_wide;
	logic signed [32:0]  wr_clamp;
	logic signed [31:0]  delta;
	logic signed [32:0]  sum;
	logic                ovf;
	logic signed [31:0]  sum_sat;

	// Handshake: stage 1 only blocks when its last step cannot hand over
	assign s1_hold   = valid_s1 && last_s1 && out_valid_q && out_stall;
	assign in_stall  = s1_hold;
	assign in_accept = in_valid && !s1_hold;
	assign fire_s2   = valid_s1 && !s1_hold;

	// Residue folding and letter decode
	always_comb begin
		chr_a = in_data.residue_a;
		chr_b = in_data.residue_b;
		if (mask_mode_q && chr_a >= CHR_LOWER_A && chr_a <= CHR_LOWER_Z) begin
			chr_a = chr_a - CASE_OFFSET;
		end
		if (mask_mode_q && chr_b >= CHR_LOWER_A && chr_b <= CHR_LOWER_Z) begin
			chr_b = chr_b - CASE_OFFSET;
		end
		idx_a = LETTER_W'(chr_a - CHR_UPPER_A);
		idx_b = LETTER_W'(chr_b - CHR_UPPER_A);
		ok_a  = chr_a >= CHR_UPPER_A && chr_a <= CHR_UPPER_Z && {1'b0, idx_a} < ALPHA_LIM;
		ok_b  = chr_b >= CHR_UPPER_A && chr_b <= CHR_UPPER_Z && {1'b0, idx_b} < ALPHA_LIM;
		rd_addr = ADDR_W'(idx_a) * ALPHA_A + ADDR_W'(idx_b);
	end

	// Table write decode with clamp to the entry width
	always_comb begin
		wr_en = in_accept && in_data.req_type == REQ_TABLE
			&& {1'b0, in_data.table_row} < ALPHA_LIM
			&& {1'b0, in_data.table_col} < ALPHA_LIM;
		wr_addr = ADDR_W'(in_data.table_row) * ALPHA_A + ADDR_W'(in_data.table_col);
		wr_wide = 33'(in_data.table_value);
		if (wr_wide > SCORE_HI) begin
			wr_clamp = SCORE_HI;
		end else if (wr_wide < SCORE_LO) begin
			wr_clamp = SCORE_LO;
		end else begin
			wr_clamp = wr_wide;
		end
	end

	// Substitution table: one write and one registered read per cycle, each only when an input is accepted
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= SCORE_WIDTH'(wr_clamp);
		end
		if (in_accept) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_open_q   <= GAP_OPEN_RST;
			gap_extend_q <= GAP_EXTEND_RST;
			mask_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAP_OPEN:   gap_open_q   <= cfg_data;
				CFG_GAP_EXTEND: gap_extend_q <= cfg_data;
				CFG_MASK_MODE:  mask_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 1 register: path steps only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= OP_MATCH;
			last_s1  <= 1'b0;
			hit_s1   <= 1'b0;
		end else if (!s1_hold) begin
			valid_s1 <= in_accept && in_data.req_type == REQ_STEP;
			op_s1    <= in_data.path_op;
			last_s1  <= in_data.last_step;
			hit_s1   <= ok_a && ok_b;
		end
	end

	// Step score
	always_comb begin
		case (op_s1) inside
			OP_MATCH:  delta = hit_s1 ? 32'(rdata_s1) : 32'sd0;
			OP_DELETE,
			OP_INSERT: delta = (prev_op_q == OP_MATCH) ? 32'(gap_open_q) : 32'(gap_extend_q);
			default:   delta = 32'sd0;
		endcase
		sum = 33'(score_q) + 33'(delta);
		ovf = sum[32] != sum[31];
		if (ovf) begin
			sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sum_sat = sum[31:0];
		end
	end

	// Stage 2: accumulate, emit on the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q     <= '0;
			prev_op_q   <= OP_MATCH;
			sat_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// Output register loads a finished score or empties when taken
			if (fire_s2 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fire_s2) begin
				if (last_s1) begin
					out_q.path_score <= sum_sat;
					out_q.saturated  <= sat_seen_q || ovf;
					score_q          <= '0;
					prev_op_q        <= OP_MATCH;
					sat_seen_q       <= 1'b0;
				end else begin
					score_q    <= sum_sat;
					prev_op_q  <= op_s1;
					sat_seen_q <= sat_seen_q || ovf;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	`AGPS_ASSERT_NOW(a_out_from_last, $rose(out_valid_q),
		$past(valid_s1 && last_s1), "result without a last step")
	`AGPS_ASSERT_NEXT(a_path_cleared, fire_s2 && last_s1,
		score_q == 32'sd0 && !sat_seen_q && prev_op_q == OP_MATCH,
		"path state not cleared after result")
	`AGPS_ASSERT_NEXT(a_write_no_step, in_accept && in_data.req_type == REQ_TABLE,
		!valid_s1, "table write entered the path")

endmodule
